### design/pulse_wave_channel_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pulse wave channel
// Shared forms for the concurrent checks in the channel's modules.
// ----------------------------------------------------------------------------
`ifndef PULSE_WAVE_CHANNEL_ASSERT_SVH
`define PULSE_WAVE_CHANNEL_ASSERT_SVH

// Same-cycle implication, checked at every clock edge out of reset.
`define PWC_ASSERT_NOW(label, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (effect)) \
        else $error(msg);

// Next-cycle implication, checked at every clock edge out of reset.
`define PWC_ASSERT_NEXT(label, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);

`endif

### design/pwc_pkg.sv
// ----------------------------------------------------------------------------
// Pulse wave channel package
// Request and result types, event codes, lookup tables and sweep arithmetic.
// ----------------------------------------------------------------------------
package pwc_pkg;

    // Event codes carried by a request.
    typedef enum logic [2:0] {
        OP_WRITE   = 3'd0,
        OP_ENABLE  = 3'd1,
        OP_QUARTER = 3'd2,
        OP_HALF    = 3'd3,
        OP_TICK    = 3'd4
    } op_t;

    // Channel register addresses.
    localparam logic [1:0] REG_DUTY_ENV  = 2'd0;
    localparam logic [1:0] REG_SWEEP     = 2'd1;
    localparam logic [1:0] REG_PERIOD_LO = 2'd2;
    localparam logic [1:0] REG_PERIOD_HI = 2'd3;

    localparam logic [10:0] MIN_PERIOD = 11'd8;
    localparam logic [3:0]  DECAY_TOP  = 4'd15;

    typedef struct packed {
        op_t        op;
        logic [1:0] reg_addr;
        logic [7:0] reg_value;
    } pwc_in_t;

    typedef struct packed {
        logic [3:0] sample;
        logic       length_active;
    } pwc_out_t;

    // Duty waveform: one bit per sequencer step.
    function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] step);
        logic [7:0] wave;
        begin
            unique case (sel)
                2'd0: wave = 8'b0000_0010;
                2'd1: wave = 8'b0000_0110;
                2'd2: wave = 8'b0001_1110;
                default: wave = 8'b1111_1001;
            endcase
            duty_bit = wave[step];
        end
    endfunction

    // Length counter load values.
    function automatic logic [7:0] length_load(input logic [4:0] idx);
        begin
            unique case (idx)
                5'd0:  length_load = 8'd10;
                5'd1:  length_load = 8'd254;
                5'd2:  length_load = 8'd20;
                5'd3:  length_load = 8'd2;
                5'd4:  length_load = 8'd40;
                5'd5:  length_load = 8'd4;
                5'd6:  length_load = 8'd80;
                5'd7:  length_load = 8'd6;
                5'd8:  length_load = 8'd160;
                5'd9:  length_load = 8'd8;
                5'd10: length_load = 8'd60;
                5'd11: length_load = 8'd10;
                5'd12: length_load = 8'd14;
                5'd13: length_load = 8'd12;
                5'd14: length_load = 8'd26;
                5'd15: length_load = 8'd14;
                5'd16: length_load = 8'd12;
                5'd17: length_load = 8'd16;
                5'd18: length_load = 8'd24;
                5'd19: length_load = 8'd18;
                5'd20: length_load = 8'd48;
                5'd21: length_load = 8'd20;
                5'd22: length_load = 8'd96;
                5'd23: length_load = 8'd22;
                5'd24: length_load = 8'd192;
                5'd25: length_load = 8'd24;
                5'd26: length_load = 8'd72;
                5'd27: length_load = 8'd26;
                5'd28: length_load = 8'd16;
                5'd29: length_load = 8'd28;
                5'd30: length_load = 8'd32;
                default: length_load = 8'd30;
            endcase
        end
    endfunction

    // Sweep target period. Negation subtracts one extra for ones' complement
    // and saturates at zero; the upper bit flags an overflow past 0x7FF.
    function automatic logic [11:0] sweep_target(
        input logic [10:0] period,
        input logic [2:0]  shift,
        input logic        negate,
        input logic        ones_comp
    );
        logic [11:0] change;
        logic [11:0] sub;
        begin
            change = {1'b0, period >> shift};
            sub    = change + {11'd0, ones_comp};
            if (!negate)
                sweep_target = {1'b0, period} + change;
            else if (sub > {1'b0, period})
                sweep_target = 12'd0;
            else
                sweep_target = {1'b0, period} - sub;
        end
    endfunction

endpackage

### design/pwc_core.sv
// ----------------------------------------------------------------------------
// Pulse wave channel core
// Channel state, updated in one pass for one request per clock with push high.
// ----------------------------------------------------------------------------
`include "pulse_wave_channel_assert.svh"

module pwc_core
    import pwc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  pwc_in_t  req,
    input  logic     cfg_wr_en,
    input  logic     cfg_wr_data,
    output pwc_out_t result
);

    logic        channel_index_reg;
    logic [1:0]  duty_select_reg, duty_select_next;
    logic        loop_halt_reg, loop_halt_next;
    logic        constant_volume_reg, constant_volume_next;
    logic [3:0]  envelope_param_reg, envelope_param_next;
    logic        sweep_enable_reg, sweep_enable_next;
    logic        sweep_negate_reg, sweep_negate_next;
    logic [2:0]  sweep_period_reg, sweep_period_next;
    logic [2:0]  sweep_shift_reg, sweep_shift_next;
    logic [2:0]  sweep_divider_reg, sweep_divider_next;
    logic        sweep_reload_reg, sweep_reload_next;
    logic        muted_reg, muted_next;
    logic [10:0] timer_period_reg, timer_period_next;
    logic [11:0] timer_count_reg, timer_count_next;
    logic [2:0]  step_position_reg, step_position_next;
    logic [7:0]  length_count_reg, length_count_next;
    logic        channel_on_reg, channel_on_next;
    logic        envelope_start_reg, envelope_start_next;
    logic [3:0]  envelope_decay_reg, envelope_decay_next;
    logic [3:0]  envelope_divider_reg, envelope_divider_next;

    logic [11:0] cur_target;
    logic [11:0] next_target;
    logic [3:0]  volume;
    logic [7:0]  v;

    assign v = req.reg_value;

    // Sweep target from the present state, used by a half clock.
    assign cur_target = sweep_target(timer_period_reg, sweep_shift_reg,
                                     sweep_negate_reg, ~channel_index_reg);

    // State update for one request.
    always_comb
    begin
        duty_select_next      = duty_select_reg;
        loop_halt_next        = loop_halt_reg;
        constant_volume_next  = constant_volume_reg;
        envelope_param_next   = envelope_param_reg;
        sweep_enable_next     = sweep_enable_reg;
        sweep_negate_next     = sweep_negate_reg;
        sweep_period_next     = sweep_period_reg;
        sweep_shift_next      = sweep_shift_reg;
        sweep_divider_next    = sweep_divider_reg;
        sweep_reload_next     = sweep_reload_reg;
        timer_period_next     = timer_period_reg;
        timer_count_next      = timer_count_reg;
        step_position_next    = step_position_reg;
        length_count_next     = length_count_reg;
        channel_on_next       = channel_on_reg;
        envelope_start_next   = envelope_start_reg;
        envelope_decay_next   = envelope_decay_reg;
        envelope_divider_next = envelope_divider_reg;

        unique case (req.op)
            OP_WRITE:
            begin
                unique case (req.reg_addr)
                    REG_DUTY_ENV:
                    begin
                        duty_select_next     = v[7:6];
                        loop_halt_next       = v[5];
                        constant_volume_next = v[4];
                        envelope_param_next  = v[3:0];
                    end
                    REG_SWEEP:
                    begin
                        sweep_enable_next = v[7];
                        sweep_period_next = v[6:4];
                        sweep_negate_next = v[3];
                        sweep_shift_next  = v[2:0];
                        sweep_reload_next = 1'b1;
                    end
                    REG_PERIOD_LO:
                    begin
                        timer_period_next = {timer_period_reg[10:8], v};
                    end
                    default:
                    begin
                        timer_period_next = {v[2:0], timer_period_reg[7:0]};
                        if (channel_on_reg)
                            length_count_next = length_load(v[7:3]);
                        step_position_next  = 3'd0;
                        envelope_start_next = 1'b1;
                    end
                endcase
            end
            OP_ENABLE:
            begin
                channel_on_next = v[0];
                if (!v[0])
                    length_count_next = 8'd0;
            end
            OP_QUARTER:
            begin
                if (envelope_start_reg)
                begin
                    envelope_start_next   = 1'b0;
                    envelope_decay_next   = DECAY_TOP;
                    envelope_divider_next = envelope_param_reg;
                end
                else if (envelope_divider_reg == 4'd0)
                begin
                    envelope_divider_next = envelope_param_reg;
                    if (envelope_decay_reg != 4'd0)
                        envelope_decay_next = envelope_decay_reg - 4'd1;
                    else if (loop_halt_reg)
                        envelope_decay_next = DECAY_TOP;
                end
                else
                begin
                    envelope_divider_next = envelope_divider_reg - 4'd1;
                end
            end
            OP_HALF:
            begin
                if (sweep_divider_reg == 3'd0 && sweep_enable_reg &&
                    sweep_shift_reg != 3'd0 && !muted_reg &&
                    timer_period_reg >= MIN_PERIOD)
                    timer_period_next = cur_target[10:0];
                if (sweep_divider_reg == 3'd0 || sweep_reload_reg)
                begin
                    sweep_divider_next = sweep_period_reg;
                    sweep_reload_next  = 1'b0;
                end
                else
                begin
                    sweep_divider_next = sweep_divider_reg - 3'd1;
                end
                if (length_count_reg != 8'd0 && !loop_halt_reg)
                    length_count_next = length_count_reg - 8'd1;
            end
            OP_TICK:
            begin
                if (timer_count_reg == 12'd0)
                begin
                    timer_count_next   = {timer_period_reg, 1'b1};
                    step_position_next = step_position_reg + 3'd1;
                end
                else
                begin
                    timer_count_next = timer_count_reg - 12'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Mute flag follows the updated period and sweep setting.
    assign next_target = sweep_target(timer_period_next, sweep_shift_next,
                                      sweep_negate_next, ~channel_index_reg);
    assign muted_next  = ~sweep_negate_next & next_target[11];

    // Output level from the updated state.
    assign volume = constant_volume_next ? envelope_param_next : envelope_decay_next;

    always_comb
    begin
        result.length_active = (length_count_next != 8'd0);
        if (!muted_next && timer_period_next >= MIN_PERIOD && result.length_active &&
            duty_bit(duty_select_next, step_position_next))
            result.sample = volume;
        else
            result.sample = 4'd0;
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            channel_index_reg <= 1'b0;
        else if (cfg_wr_en)
            channel_index_reg <= cfg_wr_data;
    end

    // Channel state registers, advanced once per accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_select_reg      <= '0;
            loop_halt_reg        <= 1'b0;
            constant_volume_reg  <= 1'b0;
            envelope_param_reg   <= '0;
            sweep_enable_reg     <= 1'b0;
            sweep_negate_reg     <= 1'b0;
            sweep_period_reg     <= '0;
            sweep_shift_reg      <= '0;
            sweep_divider_reg    <= '0;
            sweep_reload_reg     <= 1'b0;
            muted_reg            <= 1'b0;
            timer_period_reg     <= '0;
            timer_count_reg      <= '0;
            step_position_reg    <= '0;
            length_count_reg     <= '0;
            channel_on_reg       <= 1'b0;
            envelope_start_reg   <= 1'b0;
            envelope_decay_reg   <= '0;
            envelope_divider_reg <= '0;
        end
        else if (push)
        begin
            duty_select_reg      <= duty_select_next;
            loop_halt_reg        <= loop_halt_next;
            constant_volume_reg  <= constant_volume_next;
            envelope_param_reg   <= envelope_param_next;
            sweep_enable_reg     <= sweep_enable_next;
            sweep_negate_reg     <= sweep_negate_next;
            sweep_period_reg     <= sweep_period_next;
            sweep_shift_reg      <= sweep_shift_next;
            sweep_divider_reg    <= sweep_divider_next;
            sweep_reload_reg     <= sweep_reload_next;
            muted_reg            <= muted_next;
            timer_period_reg     <= timer_period_next;
            timer_count_reg      <= timer_count_next;
            step_position_reg    <= step_position_next;
            length_count_reg     <= length_count_next;
            channel_on_reg       <= channel_on_next;
            envelope_start_reg   <= envelope_start_next;
            envelope_decay_reg   <= envelope_decay_next;
            envelope_divider_reg <= envelope_divider_next;
        end
    end

    // A disabled channel cannot hold a running length counter.
    `PWC_ASSERT_NOW(a_off_no_length, push && !channel_on_next, !result.length_active, "length running while channel disabled")

endmodule

### design/pwc_out_buf.sv
// ----------------------------------------------------------------------------
// Pulse wave channel output buffer
// Result register with one skid entry, so a request is taken while a result waits.
// ----------------------------------------------------------------------------
`include "pulse_wave_channel_assert.svh"

module pwc_out_buf
    import pwc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  pwc_out_t push_data,
    output logic     full,
    output logic     res_valid,
    input  logic     res_stall,
    output pwc_out_t res
);

    logic     out_valid_reg;
    pwc_out_t out_data_reg;
    logic     skid_valid_reg;
    pwc_out_t skid_data_reg;
    logic     pop;

    assign pop       = out_valid_reg & ~res_stall;
    assign full      = skid_valid_reg;
    assign res_valid = out_valid_reg;
    assign res       = out_data_reg;

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result data, no reset needed.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_data_reg <= push_data;
            else
                out_data_reg <= push_data;
        end
    end

    `PWC_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid entry without result entry")
    `PWC_ASSERT_NOW(a_no_push_when_full, push, !skid_valid_reg, "request taken while buffer full")
    `PWC_ASSERT_NEXT(a_skid_holds, skid_valid_reg && res_stall, skid_valid_reg, "skid entry lost while stalled")

endmodule

### design/pulse_wave_channel.sv
// ----------------------------------------------------------------------------
// Pulse wave channel
// Square-wave sound channel with envelope, sweep, length counter and timer.
// ----------------------------------------------------------------------------
// Each request is one event (register write, enable write, quarter clock,
// half clock or CPU tick). The block takes one request per clock while
// req_stall is low and gives one result for it, updating all state in a
// single pass into the two-entry output buffer (result register plus skid
// entry), which lets requests keep flowing while a result waits; requests
// stall only when both entries are occupied. The channel_index register is
// written through cfg_wr_en / cfg_wr_data, which the user must do only while
// no request is in flight; the block itself does not enforce this.
module pulse_wave_channel
    import pwc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  pwc_in_t  req,
    output logic     res_valid,
    input  logic     res_stall,
    output pwc_out_t res,
    input  logic     cfg_wr_en,
    input  logic     cfg_wr_data
);

    logic     push;
    logic     full;
    pwc_out_t result;

    // A request is taken whenever the output buffer has room.
    assign req_stall = full;
    assign push      = req_valid & ~full;

    pwc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .req         (req),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .result      (result)
    );

    pwc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .full      (full),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule
